@@ rtl/rfd_pkg.sv @@
// Shared types, constants and helpers for the RGB565 frame-difference block.
// No dependencies; used by every module under rtl/ except rfd_checker.
`timescale 1ns / 1ps

package rfd_pkg;

  localparam int unsigned FRAME_WIDTH  = 320;
  localparam int unsigned FRAME_HEIGHT = 240;
  localparam int unsigned FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned POS_W        = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  localparam int unsigned PIX_W   = 16;
  localparam int unsigned THR_W   = 6;
  localparam int unsigned COUNT_W = 17;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [PIX_W-1:0]   pixel_t;
  typedef logic [THR_W-1:0]   thr_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam pos_t   POS_LAST   = pos_t'(FRAME_PIXELS - 1);
  localparam thr_t   THR_RESET  = thr_t'(25);
  localparam count_t COUNT_MAX  = '1;

  // Field masks of an RGB565 word
  localparam pixel_t RED_MASK   = 16'hF800;
  localparam pixel_t GREEN_MASK = 16'h07E0;
  localparam pixel_t BLUE_MASK  = 16'h001F;

  // Word in the compare stage: current pixel, reference and frame marker
  typedef struct packed {
    pixel_t pixel;
    pixel_t ref_pixel;
    logic   last;
  } item_t;

  typedef struct packed {
    pixel_t diff_pixel;
    logic   changed;
    count_t changed_count;
    logic   frame_last;
  } result_t;

  function automatic logic [5:0] abs_diff6(input logic [5:0] a, input logic [5:0] b);
    abs_diff6 = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

@@ rtl/rfd_frame_store.sv @@
// Reference frame store: one write port, one registered read port.
// Depends on rfd_pkg for depth and word types.
`timescale 1ns / 1ps

module rfd_frame_store (
  input  logic          clk,
  input  logic          rd_en,
  input  rfd_pkg::pos_t rd_addr,
  output rfd_pkg::pixel_t rd_data,
  input  logic          wr_en,
  input  rfd_pkg::pos_t wr_addr,
  input  rfd_pkg::pixel_t wr_data
);

  rfd_pkg::pixel_t mem [rfd_pkg::FRAME_PIXELS];
  rfd_pkg::pixel_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read-during-write to the same entry returns the old word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/rfd_diff_unit.sv @@
// Per-channel compare against threshold and the saturating changed count.
// Depends on rfd_pkg for item/result structs and abs_diff6.
`timescale 1ns / 1ps

module rfd_diff_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  rfd_pkg::item_t       item,
  input  rfd_pkg::thr_t        thr,
  output rfd_pkg::result_t     result
);

  rfd_pkg::count_t count_r;
  rfd_pkg::count_t count_nxt;
  rfd_pkg::count_t count_new;
  rfd_pkg::pixel_t cur_red, cur_green, cur_blue;
  rfd_pkg::pixel_t ref_red, ref_green, ref_blue;
  logic [5:0]      d_red, d_green, d_blue;
  logic            changed;

  always_comb begin
    cur_red   = item.pixel & rfd_pkg::RED_MASK;
    cur_green = item.pixel & rfd_pkg::GREEN_MASK;
    cur_blue  = item.pixel & rfd_pkg::BLUE_MASK;
    ref_red   = item.ref_pixel & rfd_pkg::RED_MASK;
    ref_green = item.ref_pixel & rfd_pkg::GREEN_MASK;
    ref_blue  = item.ref_pixel & rfd_pkg::BLUE_MASK;

    d_red   = rfd_pkg::abs_diff6({1'b0, cur_red[15:11]}, {1'b0, ref_red[15:11]});
    d_green = rfd_pkg::abs_diff6(cur_green[10:5], ref_green[10:5]);
    d_blue  = rfd_pkg::abs_diff6({1'b0, cur_blue[4:0]}, {1'b0, ref_blue[4:0]});

    changed = (d_red > thr) || (d_green > thr) || (d_blue > thr);

    count_new = (changed && (count_r != rfd_pkg::COUNT_MAX)) ?
                count_r + rfd_pkg::count_t'(1) : count_r;

    count_nxt = count_r;
    if (step) begin
      count_nxt = item.last ? '0 : count_new;
    end

    result.diff_pixel    = changed ? item.pixel : '0;
    result.changed       = changed;
    result.changed_count = count_new;
    result.frame_last    = item.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/rgb565_frame_difference.sv @@
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_pixel_in[15:0]
// out      output     out_valid/out_stall out_diff_pixel, out_changed,
//                                         out_changed_count, out_frame_last
// cfg      input      cfg_valid/cfg_ready cfg_diff_threshold[5:0]
//
// One word per cycle while not stalled; each word registers in s1, then out_r.
// The frame store is read on accept and written back from the compare stage;
// a same-entry hit in consecutive words is forwarded around the store.
// Reset is synchronous; no clearing pass: until the first frame completes,
// reference reads are taken as zero. Output stall backs up into in_stall.
//
// Top level; depends on rfd_pkg, rfd_frame_store and rfd_diff_unit.
`timescale 1ns / 1ps

module rgb565_frame_difference (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_diff_pixel,
  output logic        out_changed,
  output logic [16:0] out_changed_count,
  output logic        out_frame_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_diff_threshold
);

  rfd_pkg::pos_t    pos_r, pos_nxt;
  logic             filled_r, filled_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  rfd_pkg::pixel_t  s1_pixel_r;
  rfd_pkg::pos_t    s1_pos_r;
  logic             s1_last_r;
  logic             s1_blank_r;
  logic             fwd_r;
  rfd_pkg::pixel_t  fwd_pixel_r;
  rfd_pkg::thr_t    thr_r;
  logic             out_valid_r, out_valid_nxt;
  rfd_pkg::result_t out_r;

  logic             in_accept;
  logic             advance;
  logic             s1_move;
  logic             pos_last;
  rfd_pkg::pixel_t  rd_data;
  rfd_pkg::item_t   item;
  rfd_pkg::result_t result;

  assign advance   = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign pos_last  = (pos_r == rfd_pkg::POS_LAST);
  assign cfg_ready = 1'b1;

  rfd_frame_store u_store (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (pos_r),
    .rd_data (rd_data),
    .wr_en   (s1_move),
    .wr_addr (s1_pos_r),
    .wr_data (s1_pixel_r)
  );

  always_comb begin
    item.pixel = s1_pixel_r;
    item.last  = s1_last_r;
    priority if (fwd_r) begin
      item.ref_pixel = fwd_pixel_r;
    end else if (s1_blank_r) begin
      item.ref_pixel = '0;
    end else begin
      item.ref_pixel = rd_data;
    end
  end

  rfd_diff_unit u_diff (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_move),
    .item   (item),
    .thr    (thr_r),
    .result (result)
  );

  always_comb begin
    pos_nxt       = pos_r;
    filled_nxt    = filled_r;
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      pos_nxt = pos_last ? '0 : pos_r + rfd_pkg::pos_t'(1);
      if (pos_last) begin
        filled_nxt = 1'b1;
      end
    end
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      filled_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= rfd_pkg::THR_RESET;
    end else begin
      pos_r       <= pos_nxt;
      filled_r    <= filled_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_diff_threshold;
      end
    end
  end

  // Payload of the compare stage; forward when the word ahead writes our entry
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pixel_r  <= in_pixel_in;
      s1_pos_r    <= pos_r;
      s1_last_r   <= pos_last;
      s1_blank_r  <= !filled_r;
      fwd_r       <= s1_move && (s1_pos_r == pos_r);
      fwd_pixel_r <= s1_pixel_r;
    end
    if (s1_move) begin
      out_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_diff_pixel    = out_r.diff_pixel;
  assign out_changed       = out_r.changed;
  assign out_changed_count = out_r.changed_count;
  assign out_frame_last    = out_r.frame_last;

endmodule

@@ rtl/rfd_checker.sv @@
// Port-level checks for rgb565_frame_difference, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module rfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_diff_pixel,
  input logic        out_changed,
  input logic [16:0] out_changed_count
);

  // A held result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // An accept is followed by a result on offer from the output register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("no result two cycles after accept");

  a_unchanged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_changed |-> out_diff_pixel == 16'h0000)
    else $error("unchanged pixel not zeroed");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_changed |-> out_changed_count != 17'h0)
    else $error("changed pixel with zero count");

endmodule

bind rgb565_frame_difference rfd_checker u_rfd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_diff_pixel    (out_diff_pixel),
  .out_changed       (out_changed),
  .out_changed_count (out_changed_count)
);
